[rtl/deq_pkg.sv]
// deq_pkg: shared codes, widths and defaults for the double-ended queue
// used by deq_mem, deq_ctrl and double_ended_queue; no dependencies
package deq_pkg;

    localparam int VALUE_W          = 32;
    localparam int ACTION_W         = 3;
    localparam int STATUS_W         = 2;
    localparam int DEPTH_DEF        = 64;
    localparam int ITEM_WIDTH_DEF   = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_POP_FRONT  = 3'd1,
        ACT_PUSH_REAR  = 3'd2,
        ACT_POP_REAR   = 3'd3,
        ACT_LIST       = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

endpackage

[rtl/deq_mem.sv]
// deq_mem: entry storage of the double-ended queue
// one write port, one read port with registered read data; uses deq_pkg defaults
module deq_mem
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
    localparam int PTR_W     = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [PTR_W-1:0]      wr_addr,
    input  logic [ITEM_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [PTR_W-1:0]      rd_addr,
    output logic [ITEM_WIDTH-1:0] rd_data
);

    logic [ITEM_WIDTH-1:0] mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/deq_ctrl.sv]
// deq_ctrl: head pointer, fill count, command sequencer and result registers
// drives the ports of deq_mem; uses deq_pkg codes
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
    localparam int PTR_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [VALUE_W-1:0]  item_value,
    output logic                       busy,
    output logic                       strobe,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  out_value,
    output logic                       last_of_run,
    output logic                       mem_wr_en,
    output logic [PTR_W-1:0]           mem_wr_addr,
    output logic [ITEM_WIDTH-1:0]      mem_wr_data,
    output logic                       mem_rd_en,
    output logic [PTR_W-1:0]           mem_rd_addr,
    input  logic [ITEM_WIDTH-1:0]      mem_rd_data
);

    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_LIST = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic                       strobe_reg, strobe_next;
    status_t                    status_reg, status_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic                       last_reg, last_next;

    logic [PTR_W-1:0]           head_dec;
    logic [PTR_W-1:0]           head_inc;
    logic [SUM_W-1:0]           rear_sum;
    logic [SUM_W-1:0]           back_sum;
    logic [PTR_W-1:0]           rear_pos;
    logic [PTR_W-1:0]           back_pos;
    logic                       is_full;
    logic                       is_empty;
    logic                       list_last;
    logic signed [VALUE_W-1:0]  rd_value;
    action_t                    act;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == LAST_PTR)
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // width conversion between the 32-bit ports and stored items
    generate
        if (ITEM_WIDTH == VALUE_W)
        begin : g_same
            assign mem_wr_data = item_value;
            assign rd_value    = mem_rd_data;
        end
        else if (ITEM_WIDTH > VALUE_W)
        begin : g_wide
            assign mem_wr_data = {{(ITEM_WIDTH - VALUE_W){item_value[VALUE_W-1]}}, item_value};
            assign rd_value    = mem_rd_data[VALUE_W-1:0];
        end
        else
        begin : g_narrow
            assign mem_wr_data = item_value[ITEM_WIDTH-1:0];
            assign rd_value    = {{(VALUE_W - ITEM_WIDTH){mem_rd_data[ITEM_WIDTH-1]}},
                                  mem_rd_data};
        end
    endgenerate

    assign act      = action_t'(action);
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    assign head_inc = ptr_inc(head_reg);
    assign head_dec = (head_reg == '0) ? LAST_PTR : head_reg - PTR_W'(1);
    assign rear_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign back_sum = rear_sum - SUM_W'(1);
    assign rear_pos = (rear_sum >= DEPTH_SUM) ? PTR_W'(rear_sum - DEPTH_SUM) : PTR_W'(rear_sum);
    assign back_pos = (back_sum >= DEPTH_SUM) ? PTR_W'(back_sum - DEPTH_SUM) : PTR_W'(back_sum);
    assign list_last = ((idx_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = rear_pos;
        mem_rd_en   = 1'b0;
        mem_rd_addr = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (act)
                        ACT_PUSH_FRONT, ACT_PUSH_REAR:
                        begin
                            strobe_next = 1'b1;
                            value_next  = '0;
                            last_next   = 1'b1;
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next = STAT_OK;
                                mem_wr_en   = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                if (act == ACT_PUSH_FRONT)
                                begin
                                    mem_wr_addr = head_dec;
                                    head_next   = head_dec;
                                end
                            end
                        end
                        ACT_POP_FRONT, ACT_POP_REAR:
                        begin
                            if (is_empty)
                            begin
                                strobe_next = 1'b1;
                                status_next = STAT_EMPTY;
                                value_next  = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_POP;
                                if (act == ACT_POP_FRONT)
                                begin
                                    head_next = head_inc;
                                end
                                else
                                begin
                                    mem_rd_addr = back_pos;
                                end
                            end
                        end
                        ACT_LIST:
                        begin
                            if (is_empty)
                            begin
                                strobe_next = 1'b1;
                                status_next = STAT_EMPTY;
                                value_next  = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                rd_ptr_next = head_inc;
                                idx_next    = '0;
                                state_next  = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                strobe_next = 1'b1;
                status_next = STAT_OK;
                value_next  = rd_value;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_LIST:
            begin
                strobe_next = 1'b1;
                status_next = STAT_OK;
                value_next  = rd_value;
                last_next   = list_last;
                if (list_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = rd_ptr_reg;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    idx_next    = idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign out_value   = value_reg;
    assign last_of_run = last_reg;

    // fill count stays within the ring
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count beyond depth");

    // no write into a full ring
    a_no_full_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> !is_full && state_reg == S_IDLE)
        else $error("write while full or busy");

    // the pop state always produces one final word next cycle
    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |=> strobe_reg && last_reg && state_reg == S_IDLE)
        else $error("pop result missing");

    // every listing cycle delivers a word, the last one flagged
    a_list_word: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST |=> strobe_reg && (last_reg == $past(list_last)))
        else $error("list word missing or mis-flagged");

    // a read is issued only with a non-empty ring
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en && state_reg == S_IDLE |-> !is_empty)
        else $error("read from empty ring");

endmodule

[rtl/double_ended_queue.sv]
// double_ended_queue: bounded deque of signed items kept in a ring buffer
// top level; instantiates deq_ctrl and deq_mem, uses deq_pkg
//
// usage:
//   a command word (action, item_value) is taken on a rising edge with start
//   high and busy low. actions: push front, pop front, push rear, pop rear,
//   list all. codes 5 to 7 are dropped with no answer.
//   each answer word (status, out_value, last_of_run) is shown for exactly
//   one cycle with strobe high; the receiver cannot stall, it must take it.
// timing and flow:
//   push: answer in the cycle after acceptance, busy stays low, so a new
//   command can follow every cycle.
//   pop: one memory read into the registered read data, then S_POP
//   registers the answer; busy is high in S_POP, so the next command waits.
//   list of n items: one read per cycle on the memory read port, n words
//   strobed back to back from S_LIST, each registered after its read data;
//   busy is high while in S_LIST. an empty list or pop answers one empty word.
//   a push into a full ring answers a full status and changes nothing.
// reset: rst_n clears head and count at once; no clearing pass, entries
//   are only read after being written.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [VALUE_W-1:0]  item_value,
    output logic                       strobe,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  out_value,
    output logic                       last_of_run
);

    localparam int PTR_W = $clog2(DEPTH);

    logic                  mem_wr_en;
    logic [PTR_W-1:0]      mem_wr_addr;
    logic [ITEM_WIDTH-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [PTR_W-1:0]      mem_rd_addr;
    logic [ITEM_WIDTH-1:0] mem_rd_data;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .item_value  (item_value),
        .busy        (busy),
        .strobe      (strobe),
        .status      (status),
        .out_value   (out_value),
        .last_of_run (last_of_run),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    deq_mem #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

[sim/double_ended_queue_tb.sv]
// double_ended_queue_tb: self-checking bench for the double_ended_queue block
// drives command words through start/busy and checks every strobed answer word
// against a behavioral ring-buffer deque; depends on deq_pkg and the rtl top
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int ITEM_WIDTH     = ITEM_WIDTH_DEF;
    localparam int RANDOM_WORDS   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DIR_ROWS       = 21;
    localparam int MAX_PRINTS     = 40;

    localparam logic [ACTION_W-1:0] ACT_UNUSED_5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_7 = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [STATUS_W-1:0]       st;
        logic signed [VALUE_W-1:0] val;
        logic                      last;
    } answer_t;

    typedef struct packed {
        logic [ACTION_W-1:0]       act;
        logic signed [VALUE_W-1:0] val;
        logic                      typed;
        answer_t                   ans;
    } cmd_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [ACTION_W-1:0]        action;
    logic signed [VALUE_W-1:0]  item_value;
    logic                       strobe;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  out_value;
    logic                       last_of_run;

    // behavioral copy of the ring
    logic signed [ITEM_WIDTH-1:0] deque_ring [DEPTH];
    logic [5:0]                   deque_head;
    logic [6:0]                   deque_fill;

    answer_t answer_q [$];
    int      err_cnt;
    int      quiet_cycles;
    bit      gaps_on;

    cmd_row_t dir_tab [DIR_ROWS] = '{
        '{ACT_POP_FRONT,  32'sd0,      1'b1, '{STAT_EMPTY, 32'sd0, 1'b1}},
        '{ACT_POP_REAR,   -32'sd1,     1'b1, '{STAT_EMPTY, 32'sd0, 1'b1}},
        '{ACT_LIST,       VAL_MAX,     1'b1, '{STAT_EMPTY, 32'sd0, 1'b1}},
        '{ACT_UNUSED_5,   VAL_MIN,     1'b1, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_UNUSED_6,   -32'sd1,     1'b1, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_UNUSED_7,   32'sd0,      1'b1, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_PUSH_FRONT, VAL_MAX,     1'b1, '{STAT_OK,    32'sd0, 1'b1}},
        '{ACT_PUSH_REAR,  VAL_MIN,     1'b1, '{STAT_OK,    32'sd0, 1'b1}},
        '{ACT_PUSH_FRONT, -32'sd1,     1'b1, '{STAT_OK,    32'sd0, 1'b1}},
        '{ACT_PUSH_REAR,  32'sd0,      1'b1, '{STAT_OK,    32'sd0, 1'b1}},
        '{ACT_LIST,       32'sd0,      1'b0, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_POP_FRONT,  VAL_MAX,     1'b0, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_POP_REAR,   VAL_MIN,     1'b0, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_PUSH_REAR,  32'sh5555_5555, 1'b1, '{STAT_OK, 32'sd0, 1'b1}},
        '{ACT_PUSH_FRONT, 32'shaaaa_aaaa, 1'b1, '{STAT_OK, 32'sd0, 1'b1}},
        '{ACT_LIST,       -32'sd1,     1'b0, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_POP_FRONT,  32'sd0,      1'b0, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_POP_FRONT,  32'sd0,      1'b0, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_POP_REAR,   32'sd0,      1'b0, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_POP_REAR,   32'sd0,      1'b0, '{STAT_OK,    32'sd0, 1'b0}},
        '{ACT_POP_REAR,   32'sd0,      1'b1, '{STAT_EMPTY, 32'sd0, 1'b1}}
    };

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .item_value  (item_value),
        .strobe      (strobe),
        .status      (status),
        .out_value   (out_value),
        .last_of_run (last_of_run)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    function automatic answer_t make_answer(input logic [STATUS_W-1:0] st,
                                            input logic signed [VALUE_W-1:0] v,
                                            input logic lst);
        answer_t a;
        a.st   = st;
        a.val  = v;
        a.last = lst;
        return a;
    endfunction

    // updates the ring copy and, when keep is set, queues the answer words
    task automatic predict_deque(input logic [ACTION_W-1:0] act,
                                 input logic signed [VALUE_W-1:0] v, input bit keep);
        logic [5:0]                pos;
        logic signed [VALUE_W-1:0] rd;
        answer_t                   words [$];
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_REAR:
            begin
                if (deque_fill >= DEPTH)
                    words.push_back(make_answer(STAT_FULL, '0, 1'b1));
                else
                begin
                    if (act == ACT_PUSH_FRONT)
                    begin
                        deque_head = deque_head - 6'd1;
                        pos        = deque_head;
                    end
                    else
                        pos = deque_head + deque_fill[5:0];
                    deque_ring[pos] = v[ITEM_WIDTH-1:0];
                    deque_fill      = deque_fill + 7'd1;
                    words.push_back(make_answer(STAT_OK, '0, 1'b1));
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR:
            begin
                if (deque_fill == 0)
                    words.push_back(make_answer(STAT_EMPTY, '0, 1'b1));
                else
                begin
                    if (act == ACT_POP_FRONT)
                    begin
                        pos        = deque_head;
                        deque_head = deque_head + 6'd1;
                    end
                    else
                        pos = deque_head + deque_fill[5:0] - 6'd1;
                    deque_fill = deque_fill - 7'd1;
                    rd         = deque_ring[pos];
                    words.push_back(make_answer(STAT_OK, rd, 1'b1));
                end
            end
            ACT_LIST:
            begin
                if (deque_fill == 0)
                    words.push_back(make_answer(STAT_EMPTY, '0, 1'b1));
                else
                    for (int i = 0; i < deque_fill; i++)
                    begin
                        pos = deque_head + 6'(i);
                        rd  = deque_ring[pos];
                        words.push_back(make_answer(STAT_OK, rd, (i + 1 == deque_fill)));
                    end
            end
            default:
            begin
            end
        endcase
        if (keep)
            foreach (words[i])
                answer_q.push_back(words[i]);
    endtask

    // presents one command word and returns at the edge that takes it
    task automatic issue_word(input logic [ACTION_W-1:0] act,
                              input logic signed [VALUE_W-1:0] v);
        while (gaps_on && ($urandom_range(99) < 19))
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        item_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_predicted(input logic [ACTION_W-1:0] act,
                                  input logic signed [VALUE_W-1:0] v);
        issue_word(act, v);
        predict_deque(act, v, 1'b1);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // answer word checker and watchdog
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n === 1'b1)
        begin
            if ((start && !busy) || strobe === 1'b1)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("** double_ended_queue: FAILED **");
                $finish;
            end
            if (strobe !== 1'b0)
            begin
                if (answer_q.size() == 0)
                    report_mismatch("unexpected word, status", status, '0);
                else
                begin
                    want = answer_q.pop_front();
                    if (strobe !== 1'b1)
                        report_mismatch("strobe", strobe, 1);
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                    if (out_value !== want.val)
                        report_mismatch("out_value", out_value, want.val);
                    if (last_of_run !== want.last)
                        report_mismatch("last_of_run", last_of_run, want.last);
                end
            end
        end
    end

    initial
    begin
        logic [ACTION_W-1:0]       act;
        logic signed [VALUE_W-1:0] v;
        bit                        grow;
        int                        r;
        err_cnt      = 0;
        quiet_cycles = 0;
        gaps_on      = 1'b1;
        deque_head   = '0;
        deque_fill   = '0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        action     <= '0;
        item_value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            issue_word(dir_tab[i].act, dir_tab[i].val);
            predict_deque(dir_tab[i].act, dir_tab[i].val, !dir_tab[i].typed);
            if (dir_tab[i].typed && dir_tab[i].act <= ACT_LIST)
                answer_q.push_back(dir_tab[i].ans);
        end

        // fill to capacity, then full pushes, full list, wrap-around
        // upper half of the fill goes back to back
        while (deque_fill < DEPTH)
        begin
            gaps_on = (deque_fill < 7'd32);
            send_predicted($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR,
                           pick_value());
        end
        gaps_on = 1'b1;
        send_predicted(ACT_PUSH_FRONT, VAL_MAX);
        send_predicted(ACT_PUSH_REAR, VAL_MIN);
        send_predicted(ACT_UNUSED_7, -32'sd1);
        send_predicted(ACT_LIST, '0);
        send_predicted(ACT_POP_FRONT, '0);
        send_predicted(ACT_PUSH_REAR, 32'sh1234_5678);
        send_predicted(ACT_PUSH_REAR, 32'sh0bad_cafe);
        send_predicted(ACT_LIST, '0);
        while (deque_fill > 60)
            send_predicted($urandom_range(1) ? ACT_POP_FRONT : ACT_POP_REAR, $urandom);

        // random words, drifting between growing and shrinking the queue
        grow = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if ($urandom_range(19) == 0)
                grow = !grow;
            r = $urandom_range(99);
            if (r < 4)
                act = 3'($urandom_range(7, 5));
            else if (r < 12)
                act = ACT_LIST;
            else if ($urandom_range(99) < (grow ? 75 : 25))
                act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
            else
                act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_REAR;
            v = pick_value();
            send_predicted(act, v);
        end

        start <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("** double_ended_queue: PASSED **");
        else
            $display("** double_ended_queue: FAILED **");
        $finish;
    end

endmodule
